/* sv/svse_pkg.sv */
// ----------------------------------------------------------------------------
// svse_pkg
// Type codes, field offsets and helpers for the superblock size extractor.
// ----------------------------------------------------------------------------
package svse_pkg;

  localparam int unsigned TypeW   = 4;
  localparam int unsigned OffW    = 17;
  localparam int unsigned SectorW = 13;
  localparam int unsigned SizeW   = 64;

  localparam logic [TypeW-1:0] FS_NTFS  = 4'd1;
  localparam logic [TypeW-1:0] FS_FAT32 = 4'd2;
  localparam logic [TypeW-1:0] FS_FAT16 = 4'd3;
  localparam logic [TypeW-1:0] FS_FAT12 = 4'd4;
  localparam logic [TypeW-1:0] FS_EXFAT = 4'd5;
  localparam logic [TypeW-1:0] FS_EXT2  = 4'd6;
  localparam logic [TypeW-1:0] FS_EXT3  = 4'd7;
  localparam logic [TypeW-1:0] FS_EXT4  = 4'd8;
  localparam logic [TypeW-1:0] FS_BTRFS = 4'd9;
  localparam logic [TypeW-1:0] FS_XFS   = 4'd10;

  localparam logic [OffW-1:0] OFF_NTFS_SECTORS = 17'h00028;
  localparam logic [OffW-1:0] OFF_FAT_CNT16    = 17'h00013;
  localparam logic [OffW-1:0] OFF_FAT_CNT32    = 17'h00020;
  localparam logic [OffW-1:0] OFF_FAT_BPS      = 17'h0000B;
  localparam logic [OffW-1:0] OFF_EXFAT_LEN    = 17'h00048;
  localparam logic [OffW-1:0] OFF_EXFAT_SHIFT  = 17'h0006C;
  localparam logic [OffW-1:0] OFF_EXT_SB       = 17'h00400;
  localparam logic [OffW-1:0] OFF_EXT_CNT_LO   = OFF_EXT_SB + 17'h00004;
  localparam logic [OffW-1:0] OFF_EXT_LOG_BS   = OFF_EXT_SB + 17'h00018;
  localparam logic [OffW-1:0] OFF_EXT_INCOMPAT = OFF_EXT_SB + 17'h00060;
  localparam logic [OffW-1:0] OFF_EXT_CNT_HI   = OFF_EXT_SB + 17'h00150;
  localparam logic [OffW-1:0] OFF_BTRFS_TOTAL  = 17'h10070;
  localparam logic [OffW-1:0] OFF_XFS_BSIZE    = 17'h00004;
  localparam logic [OffW-1:0] OFF_XFS_DBLOCKS  = 17'h00008;

  localparam logic [31:0]        EXT_FEAT_64BIT = 32'h0000_0080;
  localparam logic [SizeW-1:0]   EXT_BASE_BS    = 64'd1024;
  localparam logic [7:0]         EXFAT_MAX_SH   = 8'd12;
  localparam logic [SectorW-1:0] SECTOR_RESET   = 13'd512;

  function automatic logic in_field(logic [OffW-1:0] off, logic [OffW-1:0] base,
                                    logic [OffW-1:0] len);
    in_field = (off >= base) && (off < base + len);
  endfunction

  function automatic logic [63:0] put_byte(logic [63:0] r, logic [2:0] pos,
                                           logic [7:0] b);
    logic [63:0] res;
    res = r;
    res[{pos, 3'b000} +: 8] = b;
    put_byte = res;
  endfunction

endpackage

/* sv/superblock_volume_size_extractor.sv */
// ----------------------------------------------------------------------------
// superblock_volume_size_extractor
// Captures boot sector / superblock size fields from a byte stream and
// reports the volume size in bytes after the last beat of a partition.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per byte (fs_type, byte_offset, data_byte,
//   last_byte), valid/stall handshake. Non-last beats are taken one per
//   cycle. After a last beat the block stalls input while it forms the size.
//   The size is a product formed by one shift-add unit, one multiplier bit
//   per cycle, stopping as soon as the remaining multiplier bits are zero.
//   Output channel: size_bytes/size_known held in an output register until
//   taken; input beats are accepted while it waits. If the output is still
//   stalled when the next size is ready, the block holds input stall.
//   cfg_we_i writes sector_size at once; write it only while idle.
//   Reset: asynchronous, clears captured fields, output valid and the
//   sequencer, and sets sector_size to 512.
// ----------------------------------------------------------------------------
module superblock_volume_size_extractor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svse_pkg::SectorW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [svse_pkg::TypeW-1:0]    fs_type_i,
  input  logic [svse_pkg::OffW-1:0]     byte_offset_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [svse_pkg::SizeW-1:0]    size_bytes_o,
  output logic                          size_known_o
);
  import svse_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_MUL   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [SectorW-1:0] sector_q;
  logic [TypeW-1:0]   type_q;
  logic [63:0]        wide_q, wide_d;
  logic [15:0]        short_q, short_d;
  logic [31:0]        unit_q, unit_d;
  logic [31:0]        feat_q, feat_d;
  logic [31:0]        high_q, high_d;
  logic [SizeW-1:0]   mcand_q, mcand_d;
  logic [SizeW-1:0]   mplier_q, mplier_d;
  logic [SizeW-1:0]   acc_q, acc_d;
  logic               out_valid_q;
  logic [SizeW-1:0]   size_q;
  logic               known_q;
  logic               in_beat;
  logic               out_free;
  logic               load_out;
  logic [63:0]        tmp64;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_DONE) && out_free;

  // field capture
  always_comb begin
    wide_d  = wide_q;
    short_d = short_q;
    unit_d  = unit_q;
    feat_d  = feat_q;
    high_d  = high_q;
    tmp64   = '0;
    if (in_beat) begin
      unique case (fs_type_i) inside
        FS_NTFS: begin
          if (in_field(byte_offset_i, OFF_NTFS_SECTORS, 17'd8))
            wide_d = put_byte(wide_q, 3'(byte_offset_i - OFF_NTFS_SECTORS), data_byte_i);
        end
        FS_FAT32, FS_FAT16, FS_FAT12: begin
          if (in_field(byte_offset_i, OFF_FAT_CNT16, 17'd2)) begin
            tmp64   = put_byte({48'd0, short_q}, 3'(byte_offset_i - OFF_FAT_CNT16),
                               data_byte_i);
            short_d = tmp64[15:0];
          end
          if (in_field(byte_offset_i, OFF_FAT_CNT32, 17'd4))
            wide_d = put_byte(wide_q, 3'(byte_offset_i - OFF_FAT_CNT32), data_byte_i);
          if (in_field(byte_offset_i, OFF_FAT_BPS, 17'd2)) begin
            tmp64  = put_byte({48'd0, unit_q[15:0]}, 3'(byte_offset_i - OFF_FAT_BPS),
                              data_byte_i);
            unit_d = {unit_q[31:16], tmp64[15:0]};
          end
        end
        FS_EXFAT: begin
          if (in_field(byte_offset_i, OFF_EXFAT_LEN, 17'd8))
            wide_d = put_byte(wide_q, 3'(byte_offset_i - OFF_EXFAT_LEN), data_byte_i);
          if (byte_offset_i == OFF_EXFAT_SHIFT)
            unit_d = {unit_q[31:8], data_byte_i};
        end
        FS_EXT2, FS_EXT3, FS_EXT4: begin
          if (in_field(byte_offset_i, OFF_EXT_CNT_LO, 17'd4))
            wide_d = put_byte(wide_q, 3'(byte_offset_i - OFF_EXT_CNT_LO), data_byte_i);
          if (in_field(byte_offset_i, OFF_EXT_LOG_BS, 17'd4)) begin
            tmp64  = put_byte({32'd0, unit_q}, 3'(byte_offset_i - OFF_EXT_LOG_BS),
                              data_byte_i);
            unit_d = tmp64[31:0];
          end
          if (in_field(byte_offset_i, OFF_EXT_INCOMPAT, 17'd4)) begin
            tmp64  = put_byte({32'd0, feat_q}, 3'(byte_offset_i - OFF_EXT_INCOMPAT),
                              data_byte_i);
            feat_d = tmp64[31:0];
          end
          if (in_field(byte_offset_i, OFF_EXT_CNT_HI, 17'd4)) begin
            tmp64  = put_byte({32'd0, high_q}, 3'(byte_offset_i - OFF_EXT_CNT_HI),
                              data_byte_i);
            high_d = tmp64[31:0];
          end
        end
        FS_BTRFS: begin
          if (in_field(byte_offset_i, OFF_BTRFS_TOTAL, 17'd8))
            wide_d = put_byte(wide_q, 3'(byte_offset_i - OFF_BTRFS_TOTAL), data_byte_i);
        end
        FS_XFS: begin
          // big-endian fields
          if (in_field(byte_offset_i, OFF_XFS_BSIZE, 17'd4)) begin
            tmp64  = put_byte({32'd0, unit_q},
                              3'(17'd3 - (byte_offset_i - OFF_XFS_BSIZE)),
                              data_byte_i);
            unit_d = tmp64[31:0];
          end
          if (in_field(byte_offset_i, OFF_XFS_DBLOCKS, 17'd8))
            wide_d = put_byte(wide_q, 3'(17'd7 - (byte_offset_i - OFF_XFS_DBLOCKS)),
                              data_byte_i);
        end
        default: begin
        end
      endcase
    end
    if (state_q == S_SETUP) begin
      wide_d  = '0;
      short_d = '0;
      unit_d  = '0;
      feat_d  = '0;
      high_d  = '0;
    end
  end

  // operand setup and shift-add multiply
  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    state_d  = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat && last_byte_i) state_d = S_SETUP;
      end
      S_SETUP: begin
        acc_d   = '0;
        state_d = S_MUL;
        unique case (type_q) inside
          FS_NTFS: begin
            mcand_d  = wide_q;
            mplier_d = {51'd0, sector_q};
          end
          FS_FAT32, FS_FAT16, FS_FAT12: begin
            mcand_d  = (short_q != 16'd0) ? {48'd0, short_q} : {32'd0, wide_q[31:0]};
            mplier_d = (unit_q[15:0] != 16'd0) ? {48'd0, unit_q[15:0]}
                                               : {51'd0, sector_q};
          end
          FS_EXFAT: begin
            mcand_d = wide_q;
            if (unit_q[7:0] != 8'd0 && unit_q[7:0] <= EXFAT_MAX_SH)
              mplier_d = 64'd1 << unit_q[3:0];
            else
              mplier_d = {51'd0, sector_q};
          end
          FS_EXT2, FS_EXT3, FS_EXT4: begin
            mcand_d = (feat_q & EXT_FEAT_64BIT) != 32'd0 ? {high_q, wide_q[31:0]}
                                                         : {32'd0, wide_q[31:0]};
            mplier_d = (unit_q[31:6] == 26'd0) ? (EXT_BASE_BS << unit_q[5:0]) : '0;
          end
          FS_BTRFS: begin
            mcand_d  = wide_q;
            mplier_d = 64'd1;
          end
          FS_XFS: begin
            mcand_d  = wide_q;
            mplier_d = {32'd0, unit_q};
          end
          default: begin
            mcand_d  = '0;
            mplier_d = '0;
          end
        endcase
      end
      S_MUL: begin
        if (mplier_q == '0) begin
          state_d = S_DONE;
        end else begin
          if (mplier_q[0]) acc_d = acc_q + mcand_q;
          mcand_d  = {mcand_q[SizeW-2:0], 1'b0};
          mplier_d = {1'b0, mplier_q[SizeW-1:1]};
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sector_q    <= SECTOR_RESET;
      wide_q      <= '0;
      short_q     <= '0;
      unit_q      <= '0;
      feat_q      <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wide_q  <= wide_d;
      short_q <= short_d;
      unit_q  <= unit_d;
      feat_q  <= feat_d;
      high_q  <= high_d;
      if (cfg_we_i) sector_q <= cfg_data_i;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    if (in_beat && last_byte_i) type_q <= fs_type_i;
    if (load_out) begin
      size_q  <= acc_q;
      known_q <= (acc_q != '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign size_bytes_o = size_q;
  assign size_known_o = known_q;

endmodule

/* verif/tb_superblock_volume_size_extractor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_superblock_volume_size_extractor
// Streams partition start bytes into the size extractor and checks every
// reported volume size against an in-bench predictor of the captured fields.
// A directed set covers field extremes and the odd cases, then six phases of
// random partitions run under different sector sizes with random idling on
// both sides, one long receiver hold-off and one sender drain pause.
// ----------------------------------------------------------------------------
module tb_superblock_volume_size_extractor;
  import svse_pkg::*;

  localparam logic [TypeW-1:0] FS_NONE = 4'd0;
  localparam logic [TypeW-1:0] FS_TOP  = 4'd15;
  localparam logic [7:0] EXT_LOG_LIMIT = 8'd54;
  localparam int SETTLE_CYC  = 80;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BEATS = 265;
  localparam int MAX_REPORTS = 40;

  typedef enum logic [2:0] {CMD_BEAT, CMD_SYNC, CMD_CFG, CMD_HOLD, CMD_CALM} cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [TypeW-1:0]   fstype;
    logic [OffW-1:0]    offset;
    logic [7:0]         data;
    logic               last;
    logic [SectorW-1:0] sector;
  } cmd_t;

  typedef struct packed {
    logic [63:0] wide;
    logic [15:0] cnt16;
    logic [31:0] unit;
    logic [31:0] feat;
    logic [31:0] hi;
  } sb_fields_t;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             known;
  } vol_size_t;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [SectorW-1:0] cfg_data = SECTOR_RESET;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [TypeW-1:0]   fs_type  = '0;
  logic [OffW-1:0]    byte_off = '0;
  logic [7:0]         data_b   = '0;
  logic               last_b   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SizeW-1:0]   size_bytes;
  logic               size_known;
  logic               hold_req = 1'b0;
  logic               calm     = 1'b0;

  sb_fields_t         sb = '0;
  logic [SectorW-1:0] sector_cur = SECTOR_RESET;
  vol_size_t          size_q[$];
  cmd_t               plan[$];
  cmd_t               on_bus;
  logic [OffW-1:0]    span_q[$];
  int errors = 0, n_beats = 0, n_parts = 0, n_results = 0, n_zero = 0, n_cfg = 0;
  int planned = 0, n_held = 0;

  superblock_volume_size_extractor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .fs_type_i    (fs_type),
    .byte_offset_i(byte_off),
    .data_byte_i  (data_b),
    .last_byte_i  (last_b),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .size_bytes_o (size_bytes),
    .size_known_o (size_known)
  );

  always #4 clk_i = ~clk_i;

  // ---- predictor ----
  task automatic capture_beat(input logic [TypeW-1:0] t, input logic [OffW-1:0] off,
                              input logic [7:0] d);
    int rel;
    case (t)
      FS_NTFS: begin
        rel = int'(off) - int'(OFF_NTFS_SECTORS);
        if (rel >= 0 && rel < 8) sb.wide[rel*8 +: 8] = d;
      end
      FS_FAT32, FS_FAT16, FS_FAT12: begin
        rel = int'(off) - int'(OFF_FAT_CNT16);
        if (rel >= 0 && rel < 2) sb.cnt16[rel*8 +: 8] = d;
        rel = int'(off) - int'(OFF_FAT_CNT32);
        if (rel >= 0 && rel < 4) sb.wide[rel*8 +: 8] = d;
        rel = int'(off) - int'(OFF_FAT_BPS);
        if (rel >= 0 && rel < 2) sb.unit[rel*8 +: 8] = d;
      end
      FS_EXFAT: begin
        rel = int'(off) - int'(OFF_EXFAT_LEN);
        if (rel >= 0 && rel < 8) sb.wide[rel*8 +: 8] = d;
        if (off == OFF_EXFAT_SHIFT) sb.unit[7:0] = d;
      end
      FS_EXT2, FS_EXT3, FS_EXT4: begin
        rel = int'(off) - int'(OFF_EXT_CNT_LO);
        if (rel >= 0 && rel < 4) sb.wide[rel*8 +: 8] = d;
        rel = int'(off) - int'(OFF_EXT_LOG_BS);
        if (rel >= 0 && rel < 4) sb.unit[rel*8 +: 8] = d;
        rel = int'(off) - int'(OFF_EXT_INCOMPAT);
        if (rel >= 0 && rel < 4) sb.feat[rel*8 +: 8] = d;
        rel = int'(off) - int'(OFF_EXT_CNT_HI);
        if (rel >= 0 && rel < 4) sb.hi[rel*8 +: 8] = d;
      end
      FS_BTRFS: begin
        rel = int'(off) - int'(OFF_BTRFS_TOTAL);
        if (rel >= 0 && rel < 8) sb.wide[rel*8 +: 8] = d;
      end
      FS_XFS: begin
        // big-endian fields
        rel = int'(off) - int'(OFF_XFS_BSIZE);
        if (rel >= 0 && rel < 4) sb.unit[(3-rel)*8 +: 8] = d;
        rel = int'(off) - int'(OFF_XFS_DBLOCKS);
        if (rel >= 0 && rel < 8) sb.wide[(7-rel)*8 +: 8] = d;
      end
      default: ;
    endcase
  endtask

  function automatic logic [SizeW-1:0] volume_bytes(input logic [TypeW-1:0] t);
    logic [63:0] cnt, unit;
    cnt  = 64'd0;
    unit = 64'd0;
    case (t)
      FS_NTFS: begin
        cnt  = sb.wide;
        unit = 64'(sector_cur);
      end
      FS_FAT32, FS_FAT16, FS_FAT12: begin
        cnt  = (sb.cnt16 != 16'd0) ? 64'(sb.cnt16) : {32'd0, sb.wide[31:0]};
        unit = (sb.unit[15:0] != 16'd0) ? 64'(sb.unit[15:0]) : 64'(sector_cur);
      end
      FS_EXFAT: begin
        cnt  = sb.wide;
        unit = (sb.unit[7:0] >= 8'd1 && sb.unit[7:0] <= EXFAT_MAX_SH) ?
               (64'd1 << sb.unit[7:0]) : 64'(sector_cur);
      end
      FS_EXT2, FS_EXT3, FS_EXT4: begin
        cnt  = {((sb.feat & EXT_FEAT_64BIT) != 32'd0) ? sb.hi : 32'd0, sb.wide[31:0]};
        unit = (sb.unit < 32'(EXT_LOG_LIMIT)) ? (EXT_BASE_BS << sb.unit) : 64'd0;
      end
      FS_BTRFS: begin
        cnt  = sb.wide;
        unit = 64'd1;
      end
      FS_XFS: begin
        cnt  = sb.wide;
        unit = 64'(sb.unit);
      end
      default: ;
    endcase
    return cnt * unit;
  endfunction

  task automatic record_beat(input cmd_t c);
    logic [SizeW-1:0] v;
    vol_size_t        e;
    n_beats++;
    capture_beat(c.fstype, c.offset, c.data);
    if (c.last) begin
      v = volume_bytes(c.fstype);
      e.size  = v;
      e.known = (v != 64'd0);
      size_q.insert(size_q.size(), e);
      sb = '0;
      n_parts++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: got 0x%016h, want 0x%016h", $time, what, got, want);
  endtask

  // ---- stimulus plan ----
  task automatic add_beat(input logic [TypeW-1:0] t, input logic [OffW-1:0] off,
                          input logic [7:0] d, input logic last);
    cmd_t c;
    c = '0;
    c.kind = CMD_BEAT;
    c.fstype = t;
    c.offset = off;
    c.data = d;
    c.last = last;
    plan.insert(plan.size(), c);
    planned++;
  endtask

  task automatic add_ctl(input cmd_kind_e k, input logic [SectorW-1:0] v);
    cmd_t c;
    c = '0;
    c.kind = k;
    c.sector = v;
    plan.insert(plan.size(), c);
  endtask

  task automatic add_span(input logic [OffW-1:0] base, input int len);
    for (int i = 0; i < len; i++) span_q.insert(span_q.size(), base + OffW'(i));
  endtask

  task automatic list_fields(input logic [TypeW-1:0] t);
    span_q.delete();
    case (t)
      FS_NTFS: add_span(OFF_NTFS_SECTORS, 8);
      FS_FAT32, FS_FAT16, FS_FAT12: begin
        add_span(OFF_FAT_BPS, 2);
        add_span(OFF_FAT_CNT16, 2);
        add_span(OFF_FAT_CNT32, 4);
      end
      FS_EXFAT: begin
        add_span(OFF_EXFAT_LEN, 8);
        add_span(OFF_EXFAT_SHIFT, 1);
      end
      FS_EXT2, FS_EXT3, FS_EXT4: begin
        add_span(OFF_EXT_CNT_LO, 4);
        add_span(OFF_EXT_LOG_BS, 4);
        add_span(OFF_EXT_INCOMPAT, 4);
        add_span(OFF_EXT_CNT_HI, 4);
      end
      FS_BTRFS: add_span(OFF_BTRFS_TOTAL, 8);
      FS_XFS: begin
        add_span(OFF_XFS_BSIZE, 4);
        add_span(OFF_XFS_DBLOCKS, 8);
      end
      default: ;
    endcase
  endtask

  // bias unit fields toward values that give a nonzero size
  function automatic logic [7:0] field_value(input logic [TypeW-1:0] t,
                                             input logic [OffW-1:0] off);
    logic [7:0] d;
    d = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) begin
      if (t == FS_EXFAT && off == OFF_EXFAT_SHIFT) begin
        d = 8'($urandom_range(0, 13));
      end else if (t >= FS_EXT2 && t <= FS_EXT4) begin
        if (off == OFF_EXT_LOG_BS) d = 8'($urandom_range(0, 56));
        else if (off > OFF_EXT_LOG_BS && off < OFF_EXT_LOG_BS + 4) d = 8'd0;
      end else if (t >= FS_FAT32 && t <= FS_FAT12 && off < OFF_FAT_CNT32) begin
        if ($urandom_range(0, 1) == 1) d = 8'd0;
      end else if (t == FS_XFS && off >= OFF_XFS_BSIZE && off < OFF_XFS_DBLOCKS) begin
        d = (off == OFF_XFS_BSIZE + 2) ? 8'h10 : 8'h00;
      end
    end
    return d;
  endfunction

  task automatic add_partition();
    logic [TypeW-1:0] t, lt;
    logic [OffW-1:0]  offs[$];
    logic [OffW-1:0]  off;
    int r;
    r = $urandom_range(0, 21);
    if (r < 20) t = TypeW'(1 + r % 10);
    else if (r == 20) t = FS_NONE;
    else t = TypeW'($urandom_range(11, 15));
    list_fields((t == FS_NONE || t > FS_XFS) ? TypeW'($urandom_range(1, 10)) : t);
    offs = span_q;
    foreach (offs[i]) begin
      if ($urandom_range(0, 9) == 0) continue;
      if ($urandom_range(0, 7) == 0) begin
        off = ($urandom_range(0, 1) == 1) ? offs[i] : OffW'($urandom_range(0, 131071));
        add_beat(TypeW'($urandom_range(0, 15)), off, 8'($urandom_range(0, 255)), 1'b0);
      end
      add_beat(t, offs[i], field_value(t, offs[i]), 1'b0);
      if ($urandom_range(0, 15) == 0) add_beat(t, offs[i], field_value(t, offs[i]), 1'b0);
    end
    lt = ($urandom_range(0, 15) == 0) ? TypeW'($urandom_range(0, 15)) : t;
    off = ($urandom_range(0, 1) == 1) ? offs[$urandom_range(0, offs.size() - 1)] :
          OffW'($urandom_range(0, 131071));
    add_beat(lt, off, field_value(lt, off), 1'b1);
  endtask

  // ---- driver ----
  always @(posedge clk_i or negedge rst_ni) begin : drive
    cmd_t c;
    logic nxt_valid, nxt_we, nxt_hold;
    int gap_left, settle;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
      hold_req <= 1'b0;
      calm     <= 1'b0;
      gap_left = 0;
      settle   = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_we    = 1'b0;
      nxt_hold  = 1'b0;
      if (in_valid && !in_stall) begin
        record_beat(on_bus);
        nxt_valid = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (plan.size() != 0) begin
          c = plan[0];
          case (c.kind)
            CMD_BEAT: begin
              if (!calm && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 2);
              end else begin
                fs_type  <= c.fstype;
                byte_off <= c.offset;
                data_b   <= c.data;
                last_b   <= c.last;
                on_bus = c;
                nxt_valid = 1'b1;
                void'(plan.pop_front());
              end
            end
            CMD_SYNC, CMD_CFG: begin
              // CFG also lets trailing beats settle before the write
              if (size_q.size() != 0) begin
                settle = 0;
              end else if (c.kind == CMD_SYNC || settle >= SETTLE_CYC) begin
                if (c.kind == CMD_CFG) begin
                  nxt_we = 1'b1;
                  cfg_data <= c.sector;
                  sector_cur = c.sector;
                  n_cfg++;
                end
                settle = 0;
                void'(plan.pop_front());
              end else begin
                settle++;
              end
            end
            CMD_HOLD: begin
              nxt_hold = 1'b1;
              void'(plan.pop_front());
            end
            default: begin
              calm <= 1'b1;
              void'(plan.pop_front());
            end
          endcase
        end
      end
      in_valid <= nxt_valid;
      cfg_we   <= nxt_we;
      hold_req <= nxt_hold;
    end
  end

  // ---- receiver stall ----
  always @(posedge clk_i or negedge rst_ni) begin : recv
    int hold_left, stall_left;
    logic nxt;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (hold_req) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        n_held++;
        nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        nxt = 1'b1;
      end else begin
        nxt = 1'b0;
      end
      out_stall <= nxt;
    end
  end

  // ---- monitor ----
  always @(posedge clk_i) begin : check
    vol_size_t e;
    if (rst_ni && out_valid && !out_stall) begin
      n_results++;
      if (size_q.size() == 0) begin
        report_mismatch("size beat with nothing expected", size_bytes, 64'd0);
      end else begin
        e = size_q.pop_front();
        if (e.size == 64'd0) n_zero++;
        if (size_bytes !== e.size) report_mismatch("size_bytes", size_bytes, e.size);
        if (size_known !== e.known)
          report_mismatch("size_known", 64'(size_known), 64'(e.known));
      end
    end
  end

  // ---- run ----
  initial begin : run
    logic [SectorW-1:0] phase_sector[6];
    logic hold_put, pause_put;
    hold_put  = 1'b0;
    pause_put = 1'b0;

    // unknown types
    add_beat(FS_NONE, 17'h1FFFF, 8'hFF, 1'b1);
    add_beat(FS_TOP, OFF_NTFS_SECTORS, 8'hFF, 1'b1);
    // btrfs top byte only
    add_beat(FS_BTRFS, OFF_BTRFS_TOTAL + 7, 8'hFF, 1'b1);
    // ntfs product wraps
    add_beat(FS_NTFS, OFF_NTFS_SECTORS, 8'hFF, 1'b0);
    add_beat(FS_NTFS, OFF_NTFS_SECTORS + 7, 8'hFF, 1'b1);
    // fat: 32-bit count, zero bytes/sector falls back to sector size
    add_beat(FS_FAT32, OFF_FAT_CNT32 + 3, 8'h80, 1'b0);
    add_beat(FS_FAT32, OFF_FAT_CNT32, 8'h01, 1'b0);
    add_beat(FS_FAT32, OFF_FAT_BPS, 8'h00, 1'b1);
    // fat: 16-bit count wins, repeated offset overwrites
    add_beat(FS_FAT12, OFF_FAT_CNT32, 8'h55, 1'b0);
    add_beat(FS_FAT12, OFF_FAT_CNT16, 8'h11, 1'b0);
    add_beat(FS_FAT12, OFF_FAT_CNT16, 8'hFF, 1'b0);
    add_beat(FS_FAT12, OFF_FAT_BPS + 1, 8'h02, 1'b1);
    // exfat shift at the limit, then just past it
    add_beat(FS_EXFAT, OFF_EXFAT_LEN + 7, 8'hFF, 1'b0);
    add_beat(FS_EXFAT, OFF_EXFAT_SHIFT, EXFAT_MAX_SH, 1'b1);
    add_beat(FS_EXFAT, OFF_EXFAT_LEN, 8'h03, 1'b0);
    add_beat(FS_EXFAT, OFF_EXFAT_SHIFT, EXFAT_MAX_SH + 8'd1, 1'b1);
    // ext4 with 64-bit count
    add_beat(FS_EXT4, OFF_EXT_INCOMPAT, 8'h80, 1'b0);
    add_beat(FS_EXT4, OFF_EXT_CNT_HI, 8'h01, 1'b0);
    add_beat(FS_EXT4, OFF_EXT_CNT_LO, 8'hFF, 1'b0);
    add_beat(FS_EXT4, OFF_EXT_LOG_BS, 8'd2, 1'b1);
    // ext3 block size shifted out
    add_beat(FS_EXT3, OFF_EXT_CNT_LO, 8'h01, 1'b0);
    add_beat(FS_EXT3, OFF_EXT_LOG_BS, EXT_LOG_LIMIT, 1'b1);
    // xfs big-endian, 4 KiB blocks
    add_beat(FS_XFS, OFF_XFS_BSIZE + 2, 8'h10, 1'b0);
    add_beat(FS_XFS, OFF_XFS_DBLOCKS, 8'hFF, 1'b0);
    add_beat(FS_XFS, OFF_XFS_DBLOCKS + 7, 8'h01, 1'b1);

    phase_sector[0] = 13'd0;
    phase_sector[1] = 13'd8191;
    phase_sector[2] = 13'd4096;
    phase_sector[3] = 13'd1;
    phase_sector[4] = SectorW'($urandom_range(512, 4096));
    phase_sector[5] = SECTOR_RESET;
    for (int p = 0; p < 6; p++) begin
      add_ctl(CMD_CFG, phase_sector[p]);
      if (p == 5) add_ctl(CMD_CALM, '0);
      planned = 0;
      while (planned < PHASE_BEATS) begin
        add_partition();
        if (p == 1 && !pause_put && planned > 120) begin
          add_ctl(CMD_SYNC, '0);
          pause_put = 1'b1;
        end
        if (p == 2 && !hold_put && planned > 40) begin
          add_ctl(CMD_HOLD, '0);
          hold_put = 1'b1;
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (plan.size() != 0 || in_valid || size_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Run covered %0d beats in %0d partitions over %0d sector-size settings.",
             n_beats, n_parts, n_cfg + 1);
    $display("Checked %0d sizes (%0d zero); receiver hold-off lasted %0d cycles.",
             n_results, n_zero, n_held);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #4_800_000;
    $display("Timeout: %0d sizes still expected", size_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* superblock_volume_size_extractor.f */
sv/svse_pkg.sv
sv/superblock_volume_size_extractor.sv
verif/tb_superblock_volume_size_extractor.sv
